FILE: rtl/core/wavetable_note_sequencer_unit_macros.svh
// Assertion macros shared by the note sequencer RTL.
`ifndef WAVETABLE_NOTE_SEQUENCER_UNIT_MACROS_SVH
`define WAVETABLE_NOTE_SEQUENCER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define WNSQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define WNSQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WNSQ_ASSERT_IMP(label, ante, cons, msg)
`define WNSQ_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

FILE: rtl/core/wnsq_pkg.sv
// Types, constants and helpers of the wavetable note sequencer.
`default_nettype none
package wnsq_pkg;

    localparam int MAX_NOTES   = 256;
    localparam int NOTE_IDX_W  = 8;
    localparam int SONG_LEN_W  = 9;
    localparam int WAVE_LEN    = 32;
    localparam int PHASE_W     = 5;
    localparam int NUM_VOICES  = 3;
    localparam int VOICE_W     = 2;
    localparam int WAVE_ADDR_W = VOICE_W + PHASE_W;
    localparam int WAVE_DEPTH  = NUM_VOICES * WAVE_LEN;
    localparam int SAMPLE_W    = 12;
    localparam int PERIOD_W    = 16;
    localparam int DUR_W       = 8;
    localparam int BEAT_W      = 26;
    localparam int CMD_W       = 3;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 26;

    localparam logic [15:0]         DAC_CMD           = 16'h6000;
    localparam logic [BEAT_W-1:0]   BEAT_PERIOD_RESET = 26'd2500000;
    localparam logic [SONG_LEN_W-1:0] SONG_LENGTH_RESET = 9'd1;

    localparam logic [CFG_INDEX_W-1:0] CFG_BEAT_PERIOD = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SONG_LENGTH = 1'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK      = 3'd0,
        CMD_PAUSE     = 3'd1,
        CMD_REWIND    = 3'd2,
        CMD_NEXT_INST = 3'd3,
        CMD_LOAD_NOTE = 3'd4,
        CMD_LOAD_WAVE = 3'd5
    } cmd_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [DUR_W-1:0]    duration;
    } note_t;

    localparam int NOTE_W = $bits(note_t);

    typedef struct packed {
        logic [CMD_W-1:0]      command;
        logic [NOTE_IDX_W-1:0] note_index;
        logic [PERIOD_W-1:0]   note_period;
        logic [DUR_W-1:0]      note_duration;
        logic [VOICE_W-1:0]    wave_select;
        logic [PHASE_W-1:0]    wave_index;
        logic [SAMPLE_W-1:0]   wave_value;
    } item_t;

    typedef struct packed {
        logic [BEAT_W-1:0]     beat_period;
        logic [SONG_LEN_W-1:0] song_length;
    } cfg_t;

    typedef struct packed {
        logic                  we;
        logic [NOTE_IDX_W-1:0] waddr;
        note_t                 wdata;
        logic [NOTE_IDX_W-1:0] raddr;
    } note_ram_ctl_t;

    typedef struct packed {
        logic                   we;
        logic [WAVE_ADDR_W-1:0] waddr;
        logic [SAMPLE_W-1:0]    wdata;
        logic [WAVE_ADDR_W-1:0] raddr;
    } wave_ram_ctl_t;

    typedef struct packed {
        logic                emit;
        logic [SAMPLE_W-1:0] sample;
    } res_t;

    // Pointer after ptr, wrapping at the song length or the table size.
    function automatic logic [NOTE_IDX_W-1:0] next_note(
        input logic [NOTE_IDX_W-1:0] ptr,
        input logic [SONG_LEN_W-1:0] len
    );
        logic [SONG_LEN_W-1:0] sum;
        sum = {1'b0, ptr} + SONG_LEN_W'(1);
        if (sum >= len || sum >= SONG_LEN_W'(MAX_NOTES))
            return '0;
        return sum[NOTE_IDX_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/wnsq_ram.sv
// Generic single-write, single-read RAM with registered write-first read.
`default_nettype none
module wnsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (we && waddr == raddr)
            rdata <= wdata;
        else
            rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/core/wnsq_core.sv
// Sequencer state: beat and sample dividers, note pointer, table prefetch addresses.
`default_nettype none
`include "wavetable_note_sequencer_unit_macros.svh"
module wnsq_core (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   go,
    input  wire wnsq_pkg::item_t        item,
    input  wire wnsq_pkg::cfg_t         cfg,
    input  wire wnsq_pkg::note_t        note_rd,
    input  wire logic [wnsq_pkg::SAMPLE_W-1:0] wave_rd,
    output wnsq_pkg::note_ram_ctl_t     note_ctl,
    output wnsq_pkg::wave_ram_ctl_t     wave_ctl,
    output wnsq_pkg::res_t              res
);

    logic [wnsq_pkg::NOTE_IDX_W-1:0] note_pointer_reg, note_pointer_next;
    logic [wnsq_pkg::DUR_W-1:0]      beats_left_reg, beats_left_next;
    logic [wnsq_pkg::BEAT_W-1:0]     beat_counter_reg, beat_counter_next;
    logic [wnsq_pkg::PERIOD_W-1:0]   sample_counter_reg, sample_counter_next;
    logic [wnsq_pkg::PERIOD_W-1:0]   current_period_reg, current_period_next;
    logic [wnsq_pkg::PHASE_W-1:0]    wave_phase_reg, wave_phase_next;
    logic [wnsq_pkg::VOICE_W-1:0]    instrument_reg, instrument_next;
    logic                            paused_reg, paused_next;
    wnsq_pkg::note_t                 note0_reg, note0_next;

    logic [wnsq_pkg::NOTE_IDX_W-1:0] ptr_plus1;
    logic                            rest_tick;

    assign ptr_plus1 = wnsq_pkg::next_note(note_pointer_reg, cfg.song_length);

    always_comb
    begin
        logic [wnsq_pkg::BEAT_W-1:0]   bc_inc;
        logic [wnsq_pkg::DUR_W-1:0]    bl_src;
        logic [wnsq_pkg::PERIOD_W-1:0] cp;
        logic [wnsq_pkg::PERIOD_W-1:0] sc_inc;

        note_pointer_next   = note_pointer_reg;
        beats_left_next     = beats_left_reg;
        beat_counter_next   = beat_counter_reg;
        sample_counter_next = sample_counter_reg;
        current_period_next = current_period_reg;
        wave_phase_next     = wave_phase_reg;
        instrument_next     = instrument_reg;
        paused_next         = paused_reg;
        note0_next          = note0_reg;
        res.emit            = 1'b0;
        res.sample          = wave_rd;
        rest_tick           = 1'b0;
        note_ctl.we         = 1'b0;
        note_ctl.waddr      = item.note_index;
        note_ctl.wdata      = {item.note_period, item.note_duration};
        wave_ctl.we         = 1'b0;
        wave_ctl.waddr      = {item.wave_select, item.wave_index};
        wave_ctl.wdata      = item.wave_value;

        bc_inc = beat_counter_reg + wnsq_pkg::BEAT_W'(1);
        bl_src = '0;
        cp     = current_period_reg;
        sc_inc = sample_counter_reg + wnsq_pkg::PERIOD_W'(1);

        if (go)
        begin
            case (item.command)
                wnsq_pkg::CMD_TICK:
                begin
                    if (!paused_reg)
                    begin
                        beat_counter_next = bc_inc;
                        if (bc_inc >= cfg.beat_period)
                        begin
                            beat_counter_next = '0;
                            bl_src = beats_left_reg;
                            if (beats_left_reg == '0)
                            begin
                                note_pointer_next = ptr_plus1;
                                cp                = note_rd.period;
                                bl_src            = note_rd.duration;
                            end
                            beats_left_next     = bl_src - wnsq_pkg::DUR_W'(1);
                            current_period_next = cp;
                        end
                        if (cp == '0)
                        begin
                            sample_counter_next = '0;
                            rest_tick           = 1'b1;
                        end
                        else
                        begin
                            sample_counter_next = sc_inc;
                            if (sc_inc >= cp)
                            begin
                                sample_counter_next = '0;
                                res.emit            = 1'b1;
                                if (wave_phase_reg ==
                                    wnsq_pkg::PHASE_W'(wnsq_pkg::WAVE_LEN - 1))
                                    wave_phase_next = '0;
                                else
                                    wave_phase_next = wave_phase_reg + wnsq_pkg::PHASE_W'(1);
                            end
                        end
                    end
                end
                wnsq_pkg::CMD_PAUSE:
                    paused_next = ~paused_reg;
                wnsq_pkg::CMD_REWIND:
                begin
                    note_pointer_next   = '0;
                    wave_phase_next     = '0;
                    current_period_next = note0_reg.period;
                    beats_left_next     = note0_reg.duration;
                end
                wnsq_pkg::CMD_NEXT_INST:
                begin
                    if (instrument_reg == wnsq_pkg::VOICE_W'(wnsq_pkg::NUM_VOICES - 1))
                        instrument_next = '0;
                    else
                        instrument_next = instrument_reg + wnsq_pkg::VOICE_W'(1);
                end
                wnsq_pkg::CMD_LOAD_NOTE:
                begin
                    note_ctl.we = 1'b1;
                    if (item.note_index == '0)
                        note0_next = {item.note_period, item.note_duration};
                end
                wnsq_pkg::CMD_LOAD_WAVE:
                    wave_ctl.we = item.wave_select < wnsq_pkg::VOICE_W'(wnsq_pkg::NUM_VOICES);
                default:
                begin
                end
            endcase
        end

        // prefetch: next cycle sees the note after the new pointer and the new phase sample
        note_ctl.raddr = wnsq_pkg::next_note(note_pointer_next, cfg.song_length);
        wave_ctl.raddr = {instrument_next, wave_phase_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            note_pointer_reg   <= '0;
            beats_left_reg     <= '0;
            beat_counter_reg   <= '0;
            sample_counter_reg <= '0;
            current_period_reg <= '0;
            wave_phase_reg     <= '0;
            instrument_reg     <= '0;
            paused_reg         <= 1'b1;
        end
        else
        begin
            note_pointer_reg   <= note_pointer_next;
            beats_left_reg     <= beats_left_next;
            beat_counter_reg   <= beat_counter_next;
            sample_counter_reg <= sample_counter_next;
            current_period_reg <= current_period_next;
            wave_phase_reg     <= wave_phase_next;
            instrument_reg     <= instrument_next;
            paused_reg         <= paused_next;
        end
    end

    always_ff @(posedge clk)
    begin
        note0_reg <= note0_next;
    end

    `WNSQ_ASSERT_IMP(a_inst_range, 1'b1,
        instrument_reg < wnsq_pkg::VOICE_W'(wnsq_pkg::NUM_VOICES),
        "instrument out of range")
    `WNSQ_ASSERT_NXT(a_paused_hold,
        go && item.command == wnsq_pkg::CMD_TICK && paused_reg,
        $stable(beat_counter_reg) && $stable(sample_counter_reg),
        "paused tick moved counters")
    `WNSQ_ASSERT_NXT(a_rewind, go && item.command == wnsq_pkg::CMD_REWIND,
        note_pointer_reg == '0 && wave_phase_reg == '0,
        "rewind did not clear pointer and phase")
    `WNSQ_ASSERT_NXT(a_rest, rest_tick, sample_counter_reg == '0,
        "rest tick left sample counter running")

endmodule
`default_nettype wire

FILE: rtl/core/wavetable_note_sequencer_unit.sv
// Top level of the wavetable note sequencer: handshake, config, tables and result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------------
//  config  | in        | cfg_write            | cfg_index, cfg_data
//  input   | in        | in_valid / in_stall  | command, note_index, note_period, ...
//  output  | out       | out_valid / out_stall| dac_word
//
//  One beat per cycle sustained while out_stall is low: input register, one pass through the dividers, result register.
//  An input beat is registered, then any sample it emits is registered into dac_word; note and wave
//  tables are read ahead from the next-state pointer and phase, so the table reads do not lengthen that path.
//  Reset starts paused with no table clearing; tables are undefined until loaded.
//  A held result under out_stall blocks the input register; in_stall follows out_stall
//  in the same cycle while a beat waits there.
`default_nettype none
`include "wavetable_note_sequencer_unit_macros.svh"
module wavetable_note_sequencer_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [wnsq_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [wnsq_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [wnsq_pkg::CMD_W-1:0]          command,
    input  wire logic [wnsq_pkg::NOTE_IDX_W-1:0]     note_index,
    input  wire logic [wnsq_pkg::PERIOD_W-1:0]       note_period,
    input  wire logic [wnsq_pkg::DUR_W-1:0]          note_duration,
    input  wire logic [wnsq_pkg::VOICE_W-1:0]        wave_select,
    input  wire logic [wnsq_pkg::PHASE_W-1:0]        wave_index,
    input  wire logic [wnsq_pkg::SAMPLE_W-1:0]       wave_value,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [15:0]                              dac_word
);

    logic [wnsq_pkg::BEAT_W-1:0]     beat_period_reg, beat_period_next;
    logic [wnsq_pkg::SONG_LEN_W-1:0] song_length_reg, song_length_next;
    logic                            in_valid_reg, in_valid_next;
    wnsq_pkg::item_t                 item_reg;
    logic                            out_valid_reg, out_valid_next;
    logic [15:0]                     dac_word_reg;

    logic                    accept;
    logic                    go;
    wnsq_pkg::cfg_t          cfg;
    wnsq_pkg::note_t         note_rd;
    logic [wnsq_pkg::SAMPLE_W-1:0] wave_rd;
    wnsq_pkg::note_ram_ctl_t note_ctl;
    wnsq_pkg::wave_ram_ctl_t wave_ctl;
    wnsq_pkg::res_t          res;

    always_comb
    begin
        beat_period_next = beat_period_reg;
        song_length_next = song_length_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                wnsq_pkg::CFG_BEAT_PERIOD:
                    beat_period_next = cfg_data[wnsq_pkg::BEAT_W-1:0];
                wnsq_pkg::CFG_SONG_LENGTH:
                    song_length_next = cfg_data[wnsq_pkg::SONG_LEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // new song length steers the prefetch address in the write cycle itself
    assign cfg = '{beat_period: beat_period_reg, song_length: song_length_next};

    assign go       = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !go;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (go)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (go && res.emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_period_reg <= wnsq_pkg::BEAT_PERIOD_RESET;
            song_length_reg <= wnsq_pkg::SONG_LENGTH_RESET;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            beat_period_reg <= beat_period_next;
            song_length_reg <= song_length_next;
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= {command, note_index, note_period, note_duration,
                         wave_select, wave_index, wave_value};
        if (go && res.emit)
            dac_word_reg <= wnsq_pkg::DAC_CMD | {4'b0000, res.sample};
    end

    wnsq_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go),
        .item     (item_reg),
        .cfg      (cfg),
        .note_rd  (note_rd),
        .wave_rd  (wave_rd),
        .note_ctl (note_ctl),
        .wave_ctl (wave_ctl),
        .res      (res)
    );

    wnsq_ram #(
        .WIDTH (wnsq_pkg::NOTE_W),
        .DEPTH (wnsq_pkg::MAX_NOTES)
    ) u_note_ram (
        .clk   (clk),
        .we    (note_ctl.we),
        .waddr (note_ctl.waddr),
        .wdata (note_ctl.wdata),
        .raddr (note_ctl.raddr),
        .rdata (note_rd)
    );

    wnsq_ram #(
        .WIDTH (wnsq_pkg::SAMPLE_W),
        .DEPTH (wnsq_pkg::WAVE_DEPTH)
    ) u_wave_ram (
        .clk   (clk),
        .we    (wave_ctl.we),
        .waddr (wave_ctl.waddr),
        .wdata (wave_ctl.wdata),
        .raddr (wave_ctl.raddr),
        .rdata (wave_rd)
    );

    assign out_valid = out_valid_reg;
    assign dac_word  = dac_word_reg;

    `WNSQ_ASSERT_IMP(a_dac_prefix, out_valid,
        dac_word[15:12] == wnsq_pkg::DAC_CMD[15:12], "dac word lost command bits")
    `WNSQ_ASSERT_NXT(a_in_hold, in_valid_reg && !go, in_valid_reg,
        "stalled input beat dropped")
    `WNSQ_ASSERT_IMP(a_stall_cause, in_stall, out_valid_reg && out_stall,
        "input stalled without a held result")

endmodule
`default_nettype wire

FILE: sim/tb_wavetable_note_sequencer_unit.sv
// Self-checking testbench for the wavetable note sequencer: directed script, then random phases.
`timescale 1ns / 100ps
module tb_wavetable_note_sequencer_unit;
    import wnsq_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;
    localparam int IDLE_PCT     = 32;
    localparam int SETTLE       = 6;
    localparam int STUCK_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 10;

    localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd7;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_QUIET,
        ROW_WORD
    } row_kind_t;

    typedef struct packed {
        item_t       stim;
        row_kind_t   kind;
        logic [15:0] word;
    } script_row_t;

    localparam int SCRIPT_LEN = 27;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{'{CMD_TICK,      8'd0,   16'd0,     8'd0,   2'd0, 5'd0,  12'h000}, ROW_QUIET,   16'h0},
        '{'{CMD_LOAD_NOTE, 8'd0,   16'd1,     8'd255, 2'd0, 5'd0,  12'h000}, ROW_PREDICT, 16'h0},
        '{'{CMD_LOAD_NOTE, 8'd255, 16'hFFFF,  8'd1,   2'd0, 5'd0,  12'h000}, ROW_PREDICT, 16'h0},
        '{'{CMD_LOAD_WAVE, 8'd0,   16'd0,     8'd0,   2'd0, 5'd0,  12'hFFF}, ROW_PREDICT, 16'h0},
        '{'{CMD_LOAD_WAVE, 8'd0,   16'd0,     8'd0,   2'd0, 5'd1,  12'h000}, ROW_PREDICT, 16'h0},
        '{'{CMD_LOAD_WAVE, 8'd0,   16'd0,     8'd0,   2'd1, 5'd0,  12'h123}, ROW_PREDICT, 16'h0},
        '{'{CMD_LOAD_WAVE, 8'd0,   16'd0,     8'd0,   2'd2, 5'd0,  12'h800}, ROW_PREDICT, 16'h0},
        '{'{CMD_LOAD_WAVE, 8'd0,   16'd0,     8'd0,   2'd2, 5'd31, 12'h7A5}, ROW_PREDICT, 16'h0},
        '{'{CMD_LOAD_WAVE, 8'd0,   16'd0,     8'd0,   2'd3, 5'd0,  12'h555}, ROW_QUIET,   16'h0},
        '{'{CMD_RSVD_A,    8'hFF,  16'hFFFF,  8'hFF,  2'd3, 5'd31, 12'hFFF}, ROW_QUIET,   16'h0},
        '{'{CMD_RSVD_B,    8'hFF,  16'hFFFF,  8'hFF,  2'd3, 5'd31, 12'hFFF}, ROW_QUIET,   16'h0},
        '{'{CMD_REWIND,    8'd0,   16'd0,     8'd0,   2'd0, 5'd0,  12'h000}, ROW_PREDICT, 16'h0},
        '{'{CMD_TICK,      8'd0,   16'd0,     8'd0,   2'd0, 5'd0,  12'h000}, ROW_QUIET,   16'h0},
        '{'{CMD_PAUSE,     8'd0,   16'd0,     8'd0,   2'd0, 5'd0,  12'h000}, ROW_PREDICT, 16'h0},
        '{'{CMD_TICK,      8'd0,   16'd0,     8'd0,   2'd0, 5'd0,  12'h000}, ROW_WORD, 16'h6FFF},
        '{'{CMD_TICK,      8'd0,   16'd0,     8'd0,   2'd0, 5'd0,  12'h000}, ROW_WORD, 16'h6000},
        '{'{CMD_REWIND,    8'd0,   16'd0,     8'd0,   2'd0, 5'd0,  12'h000}, ROW_PREDICT, 16'h0},
        '{'{CMD_NEXT_INST, 8'd0,   16'd0,     8'd0,   2'd0, 5'd0,  12'h000}, ROW_PREDICT, 16'h0},
        '{'{CMD_TICK,      8'd0,   16'd0,     8'd0,   2'd0, 5'd0,  12'h000}, ROW_WORD, 16'h6123},
        '{'{CMD_NEXT_INST, 8'd0,   16'd0,     8'd0,   2'd0, 5'd0,  12'h000}, ROW_PREDICT, 16'h0},
        '{'{CMD_REWIND,    8'd0,   16'd0,     8'd0,   2'd0, 5'd0,  12'h000}, ROW_PREDICT, 16'h0},
        '{'{CMD_TICK,      8'd0,   16'd0,     8'd0,   2'd0, 5'd0,  12'h000}, ROW_WORD, 16'h6800},
        '{'{CMD_NEXT_INST, 8'd0,   16'd0,     8'd0,   2'd0, 5'd0,  12'h000}, ROW_PREDICT, 16'h0},
        '{'{CMD_LOAD_NOTE, 8'd0,   16'd0,     8'd0,   2'd0, 5'd0,  12'h000}, ROW_PREDICT, 16'h0},
        '{'{CMD_REWIND,    8'd0,   16'd0,     8'd0,   2'd0, 5'd0,  12'h000}, ROW_PREDICT, 16'h0},
        '{'{CMD_TICK,      8'd0,   16'd0,     8'd0,   2'd0, 5'd0,  12'h000}, ROW_QUIET,   16'h0},
        '{'{CMD_PAUSE,     8'd0,   16'd0,     8'd0,   2'd0, 5'd0,  12'h000}, ROW_PREDICT, 16'h0}
    };

    // Phases from FIXED_PHASES on draw their settings at random.
    localparam int NUM_PHASES   = 8;
    localparam int FIXED_PHASES = 6;
    localparam int CALM_PHASE   = 5;
    localparam logic [BEAT_W-1:0] PHASE_BEATS [NUM_PHASES] =
        '{26'd1, 26'd0, 26'd3, 26'h3FFFFFF, 26'd2, 26'd1, 26'd0, 26'd0};
    localparam logic [SONG_LEN_W-1:0] PHASE_SONGS [NUM_PHASES] =
        '{9'd256, 9'd7, 9'd1, 9'd256, 9'd0, 9'd256, 9'd0, 9'd0};
    localparam int PHASE_BEATS_N [NUM_PHASES] = '{600, 120, 120, 120, 120, 120, 80, 80};

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [CMD_W-1:0]      command;
    logic [NOTE_IDX_W-1:0] note_index;
    logic [PERIOD_W-1:0]   note_period;
    logic [DUR_W-1:0]      note_duration;
    logic [VOICE_W-1:0]    wave_select;
    logic [PHASE_W-1:0]    wave_index;
    logic [SAMPLE_W-1:0]   wave_value;
    logic                  out_valid;
    logic                  out_stall;
    logic [15:0]           dac_word;

    bit          no_gaps = 1'b0;
    int          err_cnt = 0;
    logic [15:0] dac_expect_q [$];

    // Predictor state
    logic [PERIOD_W-1:0]   note_periods [MAX_NOTES];
    logic [DUR_W-1:0]      note_lengths [MAX_NOTES];
    logic [SAMPLE_W-1:0]   wave_mem [NUM_VOICES][WAVE_LEN];
    logic [NOTE_IDX_W-1:0] seq_ptr;
    logic [DUR_W-1:0]      beats_rem;
    logic [BEAT_W-1:0]     beat_ticks;
    logic [PERIOD_W-1:0]   sample_ticks;
    logic [PERIOD_W-1:0]   play_period;
    logic [PHASE_W-1:0]    wave_pos;
    logic [VOICE_W-1:0]    voice_sel;
    bit                    is_paused;
    logic [BEAT_W-1:0]     cfg_beat;
    logic [SONG_LEN_W-1:0] cfg_song;

    wavetable_note_sequencer_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .note_index    (note_index),
        .note_period   (note_period),
        .note_duration (note_duration),
        .wave_select   (wave_select),
        .wave_index    (wave_index),
        .wave_value    (wave_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .dac_word      (dac_word)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic report_error(input string msg);
        if (err_cnt < MAX_REPORTS)
        begin
            $display("%s", msg);
        end
        err_cnt++;
    endtask

    task automatic finish_run();
        if (err_cnt == 0 && dac_expect_q.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    endtask

    // Advances the sequencer by one accepted beat; skipped marks beats the block ignores.
    task automatic sequencer_step(input item_t it, output bit emit, output logic [15:0] word,
                                  output bit skipped);
        logic [SONG_LEN_W-1:0] nxt;
        emit    = 1'b0;
        word    = '0;
        skipped = 1'b0;
        case (it.command)
            CMD_TICK:
            begin
                if (is_paused)
                begin
                    skipped = 1'b1;
                end
                else
                begin
                    beat_ticks = beat_ticks + 1'b1;
                    if (beat_ticks >= cfg_beat)
                    begin
                        beat_ticks = '0;
                        if (beats_rem == '0)
                        begin
                            nxt = {1'b0, seq_ptr} + 1'b1;
                            if (nxt >= cfg_song || nxt >= MAX_NOTES)
                                nxt = '0;
                            seq_ptr     = nxt[NOTE_IDX_W-1:0];
                            play_period = note_periods[seq_ptr];
                            beats_rem   = note_lengths[seq_ptr];
                        end
                        beats_rem = beats_rem - 1'b1;
                    end
                    if (play_period == '0)
                    begin
                        sample_ticks = '0;
                    end
                    else
                    begin
                        sample_ticks = sample_ticks + 1'b1;
                        if (sample_ticks >= play_period)
                        begin
                            sample_ticks = '0;
                            emit         = 1'b1;
                            word         = DAC_CMD | 16'(wave_mem[voice_sel][wave_pos]);
                            wave_pos     = wave_pos + 1'b1;
                        end
                    end
                end
            end
            CMD_PAUSE:
                is_paused = !is_paused;
            CMD_REWIND:
            begin
                seq_ptr     = '0;
                wave_pos    = '0;
                play_period = note_periods[0];
                beats_rem   = note_lengths[0];
            end
            CMD_NEXT_INST:
                voice_sel = (voice_sel == VOICE_W'(NUM_VOICES - 1)) ? '0 : voice_sel + 1'b1;
            CMD_LOAD_NOTE:
            begin
                note_periods[it.note_index] = it.note_period;
                note_lengths[it.note_index] = it.note_duration;
            end
            CMD_LOAD_WAVE:
            begin
                if (it.wave_select < NUM_VOICES)
                    wave_mem[it.wave_select][it.wave_index] = it.wave_value;
                else
                    skipped = 1'b1;
            end
            default:
                skipped = 1'b1;
        endcase
    endtask

    function automatic item_t random_item(input bit allow_rewind);
        item_t       it;
        int unsigned pick;
        int unsigned pick_period;
        pick        = $urandom_range(99);
        pick_period = $urandom_range(99);
        it.note_index = NOTE_IDX_W'($urandom_range(255));
        if (pick_period < 10)
            it.note_period = '0;
        else if (pick_period < 75)
            it.note_period = PERIOD_W'($urandom_range(4, 1));
        else if (pick_period < 95)
            it.note_period = PERIOD_W'($urandom_range(64, 5));
        else
            it.note_period = PERIOD_W'($urandom_range(16'hFFFF));
        it.note_duration = DUR_W'(($urandom_range(99) < 90) ? $urandom_range(2, 1)
                                                            : $urandom_range(255));
        it.wave_select   = VOICE_W'($urandom_range(3));
        it.wave_index    = PHASE_W'($urandom_range(31));
        it.wave_value    = SAMPLE_W'($urandom_range(12'hFFF));
        if (is_paused && pick < 50)
            it.command = CMD_PAUSE;
        else if (pick < 76)
            it.command = CMD_TICK;
        else if (pick < 78)
            it.command = CMD_PAUSE;
        else if (pick < 81)
            it.command = allow_rewind ? CMD_REWIND : CMD_TICK;
        else if (pick < 84)
            it.command = CMD_NEXT_INST;
        else if (pick < 91)
            it.command = CMD_LOAD_NOTE;
        else if (pick < 98)
            it.command = CMD_LOAD_WAVE;
        else
            it.command = $urandom_range(1) ? CMD_RSVD_B : CMD_RSVD_A;
        return it;
    endfunction

    // Presents one beat, waits for it to be taken and records what it should produce.
    task automatic send_beat(input item_t it, input row_kind_t kind, input logic [15:0] word,
                             output bit counted);
        bit          emit;
        bit          skipped;
        logic [15:0] pred_word;
        while (!no_gaps && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        command       <= it.command;
        note_index    <= it.note_index;
        note_period   <= it.note_period;
        note_duration <= it.note_duration;
        wave_select   <= it.wave_select;
        wave_index    <= it.wave_index;
        wave_value    <= it.wave_value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sequencer_step(it, emit, pred_word, skipped);
        case (kind)
            ROW_WORD:
                dac_expect_q.push_back(word);
            ROW_QUIET:
                ;
            default:
                if (emit)
                    dac_expect_q.push_back(pred_word);
        endcase
        counted = !skipped;
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (dac_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic program_regs(input logic [BEAT_W-1:0] beats,
                                input logic [SONG_LEN_W-1:0] len);
        cfg_write <= 1'b1;
        cfg_index <= CFG_BEAT_PERIOD;
        cfg_data  <= CFG_DATA_W'(beats);
        @(posedge clk);
        cfg_index <= CFG_SONG_LENGTH;
        cfg_data  <= CFG_DATA_W'(len);
        @(posedge clk);
        cfg_write <= 1'b0;
        cfg_beat  = beats;
        cfg_song  = len;
    endtask

    initial
    begin
        item_t                 it;
        bit                    counted;
        int                    done;
        logic [BEAT_W-1:0]     beats;
        logic [SONG_LEN_W-1:0] len;
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        command       = CMD_TICK;
        note_index    = '0;
        note_period   = '0;
        note_duration = '0;
        wave_select   = '0;
        wave_index    = '0;
        wave_value    = '0;
        seq_ptr       = '0;
        beats_rem     = '0;
        beat_ticks    = '0;
        sample_ticks  = '0;
        play_period   = '0;
        wave_pos      = '0;
        voice_sel     = '0;
        is_paused     = 1'b1;
        cfg_beat      = BEAT_PERIOD_RESET;
        cfg_song      = SONG_LENGTH_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < SCRIPT_LEN; r++)
            send_beat(SCRIPT[r].stim, SCRIPT[r].kind, SCRIPT[r].word, counted);

        // Load every table entry so that no later read finds one unwritten.
        for (int n = 0; n < MAX_NOTES; n++)
        begin
            it               = random_item(1'b0);
            it.command       = CMD_LOAD_NOTE;
            it.note_index    = NOTE_IDX_W'(n);
            it.note_duration = DUR_W'($urandom_range(2, 1));
            it.note_period   = ($urandom_range(9) == 0) ? '0 : PERIOD_W'($urandom_range(3, 1));
            send_beat(it, ROW_PREDICT, '0, counted);
        end
        for (int v = 0; v < NUM_VOICES; v++)
        begin
            for (int s = 0; s < WAVE_LEN; s++)
            begin
                it             = random_item(1'b0);
                it.command     = CMD_LOAD_WAVE;
                it.wave_select = VOICE_W'(v);
                it.wave_index  = PHASE_W'(s);
                send_beat(it, ROW_PREDICT, '0, counted);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_pipeline();
            beats = PHASE_BEATS[p];
            len   = PHASE_SONGS[p];
            if (p >= FIXED_PHASES)
            begin
                beats = BEAT_W'($urandom_range(6, 1));
                len   = SONG_LEN_W'($urandom_range(256, 1));
            end
            program_regs(beats, len);
            no_gaps = (p == CALM_PHASE);
            done    = 0;
            // first phase runs without rewinds so the pointer can reach the table end
            while (done < PHASE_BEATS_N[p])
            begin
                send_beat(random_item(p != 0), ROW_PREDICT, '0, counted);
                done += counted;
            end
            no_gaps = 1'b0;
        end

        drain_pipeline();
        finish_run();
    end

    initial
    begin
        logic [15:0] want;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (dac_expect_q.size() == 0)
                begin
                    report_error($sformatf("dac_word %h with no result pending", dac_word));
                end
                else
                begin
                    want = dac_expect_q.pop_front();
                    if (dac_word !== want)
                        report_error($sformatf("dac_word mismatch: expected %h, got %h",
                                               want, dac_word));
                end
            end
            out_stall <= !no_gaps && ($urandom_range(99) < IDLE_PCT);
        end
    end

    initial
    begin
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                stuck = 0;
            else
                stuck++;
        end
        $display("timeout: no beat accepted for %0d cycles", STUCK_LIMIT);
        err_cnt++;
        finish_run();
    end

endmodule
